[rtl/lpd_pkg.sv]
// Shared types, constants and register codes of the 3x3 local peak detector.
`default_nettype none

package lpd_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed field widths.
    localparam int THRESHOLD_W = 16;
    localparam int SAT_LEVEL_W = 16;
    localparam int IMG_WIDTH_W = 12;
    localparam int IMG_HEIGHT_W = 16;
    localparam int PEAK_COL_W  = 11;
    localparam int PEAK_ROW_W  = 16;
    localparam int PEAK_VAL_W  = 16;

    // Register port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_THRESHOLD  = 2'd0;
    localparam t_reg_idx REG_SAT_LEVEL  = 2'd1;
    localparam t_reg_idx REG_IMG_WIDTH  = 2'd2;
    localparam t_reg_idx REG_IMG_HEIGHT = 2'd3;

    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RST  = 16'd65535;
    localparam logic [SAT_LEVEL_W-1:0]  SAT_LEVEL_RST  = 16'd50000;
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 12'd2048;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 16'd2048;

    // Per-pixel control flags of the window stage.
    typedef struct packed {
        logic valid;
        logic interior;
        logic near_edge;
        logic frame_end;
    } t_stage_ctl;

    // One result item.
    typedef struct packed {
        logic                  peak_valid;
        logic                  frame_end;
        logic [PEAK_COL_W-1:0] peak_col;
        logic [PEAK_ROW_W-1:0] peak_row;
        logic [PEAK_VAL_W-1:0] peak_value;
        logic                  saturated;
        logic                  near_edge;
    } t_result;

endpackage

`default_nettype wire

[rtl/local_peak_detect_3x3.sv]
// Top level of the streaming 3x3 local peak detector.
`default_nettype none

// The block takes one pixel per clock in raster order and reports every interior pixel
// that reaches the threshold and is strictly greater than its eight neighbors, plus one
// frame end item on the last pixel of each frame (a peak there shares that item). An
// accepted pixel reads the two line stores (one RAM each, registered read) in its cycle
// of acceptance; in the next cycle the window stage shifts the new column in, runs the
// compare, writes the line stores back and pushes any result into a two-item output
// buffer, so a result passes the window stage registers and then that buffer before it
// is shown; the sustained rate is one pixel per cycle as long as results are taken.
// The input stalls only when that buffer would overflow. A line store entry that is
// read in its write cycle (an image one pixel wide) gets the written values forwarded.
// The line stores are not cleared after reset; they fill with the first two rows of a
// frame, and no peak test uses an unwritten entry unless the image width grows mid-frame.
// Configuration registers (threshold, saturation level, width, height) sit at byte
// addresses 0, 4, 8 and 12 and are meant to be written while no item is in flight.
// A width of zero counts as one and a width above MAX_WIDTH counts as MAX_WIDTH; a
// height of zero counts as one.
module local_peak_detect_3x3 #(
    parameter int MAX_WIDTH  = lpd_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = lpd_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Pixel input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [PIXEL_BITS-1:0]               i_pixel,
    // Result output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_peak_valid,
    output logic                                     o_frame_end,
    output logic [lpd_pkg::PEAK_COL_W-1:0]           o_peak_col,
    output logic [lpd_pkg::PEAK_ROW_W-1:0]           o_peak_row,
    output logic [lpd_pkg::PEAK_VAL_W-1:0]           o_peak_value,
    output logic                                     o_saturated,
    output logic                                     o_near_edge,
    // Register port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [lpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    // Column counter and line store address share one width; the effective width
    // needs one more code so that MAX_WIDTH itself fits.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);

    // Configuration registers.
    logic [lpd_pkg::THRESHOLD_W-1:0]  r_threshold;
    logic [lpd_pkg::SAT_LEVEL_W-1:0]  r_sat_level;
    logic [lpd_pkg::IMG_WIDTH_W-1:0]  r_img_width;
    logic [lpd_pkg::IMG_HEIGHT_W-1:0] r_img_height;
    logic                             cfg_wr;
    lpd_pkg::t_reg_idx                cfg_idx;

    // Position of the next pixel.
    logic [COL_W-1:0]                 r_col;
    logic [lpd_pkg::PEAK_ROW_W-1:0]   r_row;
    logic [COL_W-1:0]                 n_col;
    logic [lpd_pkg::PEAK_ROW_W-1:0]   n_row;

    logic [WEFF_W-1:0]                eff_width;
    logic [lpd_pkg::IMG_HEIGHT_W-1:0] eff_height;
    logic                             last_col;
    logic                             last_row;
    logic                             accept;

    // Window stage registers (the pixel accepted in the previous cycle).
    logic                             r_s1_valid;
    logic [PIXEL_BITS-1:0]            r_s1_px;
    logic [COL_W-1:0]                 r_s1_col;
    logic [lpd_pkg::PEAK_ROW_W-1:0]   r_s1_row;
    logic                             r_s1_interior;
    logic                             r_s1_near_edge;
    logic                             r_s1_frame_end;
    lpd_pkg::t_stage_ctl              s1_ctl;

    // Line store read data and forwarding of a write to the same entry.
    logic [PIXEL_BITS-1:0]            ram_a_q;
    logic [PIXEL_BITS-1:0]            ram_b_q;
    logic                             r_fwd;
    logic [PIXEL_BITS-1:0]            r_fwd_top;
    logic [PIXEL_BITS-1:0]            r_fwd_mid;
    logic [PIXEL_BITS-1:0]            s1_top;
    logic [PIXEL_BITS-1:0]            s1_mid;

    // Result path.
    logic                             push;
    lpd_pkg::t_result                 win_result;
    lpd_pkg::t_result                 out_result;
    logic [1:0]                       out_count;
    logic [2:0]                       load;
    logic                             pop;

    // ---------------------------------------------------------------------------------
    // Register port. Writes complete in the access phase; reads return the register.
    // ---------------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= lpd_pkg::THRESHOLD_RST;
            r_sat_level  <= lpd_pkg::SAT_LEVEL_RST;
            r_img_width  <= lpd_pkg::IMG_WIDTH_RST;
            r_img_height <= lpd_pkg::IMG_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                lpd_pkg::REG_THRESHOLD: begin
                    r_threshold <= pwdata[lpd_pkg::THRESHOLD_W-1:0];
                end
                lpd_pkg::REG_SAT_LEVEL: begin
                    r_sat_level <= pwdata[lpd_pkg::SAT_LEVEL_W-1:0];
                end
                lpd_pkg::REG_IMG_WIDTH: begin
                    r_img_width <= pwdata[lpd_pkg::IMG_WIDTH_W-1:0];
                end
                lpd_pkg::REG_IMG_HEIGHT: begin
                    r_img_height <= pwdata[lpd_pkg::IMG_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lpd_pkg::REG_THRESHOLD:  prdata = lpd_pkg::APB_DATA_W'(r_threshold);
            lpd_pkg::REG_SAT_LEVEL:  prdata = lpd_pkg::APB_DATA_W'(r_sat_level);
            lpd_pkg::REG_IMG_WIDTH:  prdata = lpd_pkg::APB_DATA_W'(r_img_width);
            lpd_pkg::REG_IMG_HEIGHT: prdata = lpd_pkg::APB_DATA_W'(r_img_height);
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Frame geometry and raster position. A counter that sits at or beyond a shrunk
    // size counts as the last column or row, so the stream wraps on the next pixel.
    // ---------------------------------------------------------------------------------
    always_comb begin
        if (r_img_width == '0) begin
            eff_width = WEFF_W'(1);
        end else if (r_img_width > MAX_WIDTH) begin
            eff_width = WEFF_W'(MAX_WIDTH);
        end else begin
            eff_width = WEFF_W'(r_img_width);
        end
        eff_height = (r_img_height == '0) ? lpd_pkg::IMG_HEIGHT_W'(1) : r_img_height;

        last_col = (WEFF_W'(r_col) + WEFF_W'(1)) >= eff_width;
        last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, eff_height};

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : (r_row + lpd_pkg::PEAK_ROW_W'(1));
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------------------------
    // Flow control. The window stage never stalls, so a pixel is taken only when the
    // buffer is sure to have room for the result of every item still in flight.
    // ---------------------------------------------------------------------------------
    assign pop        = o_out_valid && i_out_ready;
    assign load       = {1'b0, out_count} + {2'b00, r_s1_valid};
    assign o_in_ready = (load <= 3'd1) || ((load == 3'd2) && pop);
    assign accept     = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------------------------
    // Window stage registers. The peak test needs column and row at least two; a peak
    // one step away from the first or last column or row is near the edge.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_fwd <= r_s1_valid && (r_s1_col == r_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px        <= i_pixel;
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
            r_s1_interior  <= (r_col >= COL_W'(2)) && (r_row >= lpd_pkg::PEAK_ROW_W'(2));
            r_s1_near_edge <= (r_col == COL_W'(2)) || (r_row == lpd_pkg::PEAK_ROW_W'(2)) ||
                              last_col || last_row;
            r_s1_frame_end <= last_col && last_row;
            r_fwd_top      <= s1_mid;
            r_fwd_mid      <= r_s1_px;
        end
    end

    // The entry read in the acceptance cycle may have been written in that same cycle.
    assign s1_top = r_fwd ? r_fwd_top : ram_b_q;
    assign s1_mid = r_fwd ? r_fwd_mid : ram_a_q;

    always_comb begin
        s1_ctl.valid     = r_s1_valid;
        s1_ctl.interior  = r_s1_interior;
        s1_ctl.near_edge = r_s1_near_edge;
        s1_ctl.frame_end = r_s1_frame_end;
    end

    // ---------------------------------------------------------------------------------
    // Line stores: store A holds the row above, store B the row two above. The window
    // stage writes the current pixel into A and moves the old A value into B.
    // ---------------------------------------------------------------------------------
    lpd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_px),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_a_q)
    );

    lpd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (s1_mid),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_b_q)
    );

    lpd_window #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s1_ctl),
        .i_top       (s1_top),
        .i_mid       (s1_mid),
        .i_px        (r_s1_px),
        .i_col       (r_s1_col),
        .i_row       (r_s1_row),
        .i_threshold (r_threshold),
        .i_sat_level (r_sat_level),
        .o_push      (push),
        .o_result    (win_result)
    );

    lpd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (win_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result),
        .o_count  (out_count)
    );

    assign o_peak_valid = out_result.peak_valid;
    assign o_frame_end  = out_result.frame_end;
    assign o_peak_col   = out_result.peak_col;
    assign o_peak_row   = out_result.peak_row;
    assign o_peak_value = out_result.peak_value;
    assign o_saturated  = out_result.saturated;
    assign o_near_edge  = out_result.near_edge;

endmodule

`default_nettype wire

[rtl/lpd_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lpd_ram #(
    parameter int WIDTH = lpd_pkg::PIXEL_BITS_DEF,
    parameter int DEPTH = lpd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/lpd_window.sv]
// 3x3 window registers and the strict local maximum test.
`default_nettype none

module lpd_window #(
    parameter int PIXEL_BITS = lpd_pkg::PIXEL_BITS_DEF,
    parameter int COL_W      = $clog2(lpd_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lpd_pkg::t_stage_ctl                 i_ctl,
    input  wire logic [PIXEL_BITS-1:0]               i_top,
    input  wire logic [PIXEL_BITS-1:0]               i_mid,
    input  wire logic [PIXEL_BITS-1:0]               i_px,
    input  wire logic [COL_W-1:0]                    i_col,
    input  wire logic [lpd_pkg::PEAK_ROW_W-1:0]      i_row,
    input  wire logic [lpd_pkg::THRESHOLD_W-1:0]     i_threshold,
    input  wire logic [lpd_pkg::SAT_LEVEL_W-1:0]     i_sat_level,
    output logic                                     o_push,
    output lpd_pkg::t_result                         o_result
);

    // Each row keeps the two most recent columns: c (left after shift) and r (centre).
    logic [PIXEL_BITS-1:0] r_top_c, r_top_r;
    logic [PIXEL_BITS-1:0] r_mid_c, r_mid_r;
    logic [PIXEL_BITS-1:0] r_bot_c, r_bot_r;
    logic [PIXEL_BITS-1:0] centre;
    logic                  is_max;
    logic                  peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_c <= '0;
            r_top_r <= '0;
            r_mid_c <= '0;
            r_mid_r <= '0;
            r_bot_c <= '0;
            r_bot_r <= '0;
        end else if (i_ctl.valid) begin
            r_top_c <= r_top_r;
            r_top_r <= i_top;
            r_mid_c <= r_mid_r;
            r_mid_r <= i_mid;
            r_bot_c <= r_bot_r;
            r_bot_r <= i_px;
        end
    end

    always_comb begin
        centre = r_mid_r;
        is_max = (r_top_c < centre) && (r_top_r < centre) && (i_top < centre) &&
                 (r_mid_c < centre) && (i_mid < centre) &&
                 (r_bot_c < centre) && (r_bot_r < centre) && (i_px < centre);
        peak   = i_ctl.interior && (centre >= i_threshold) && is_max;

        o_result            = '0;
        o_result.peak_valid = peak;
        o_result.frame_end  = i_ctl.frame_end;
        if (peak) begin
            o_result.peak_col   = lpd_pkg::PEAK_COL_W'(i_col - COL_W'(1));
            o_result.peak_row   = i_row - lpd_pkg::PEAK_ROW_W'(1);
            o_result.peak_value = lpd_pkg::PEAK_VAL_W'(centre);
            o_result.saturated  = centre > i_sat_level;
            o_result.near_edge  = i_ctl.near_edge;
        end
        o_push = i_ctl.valid && (peak || i_ctl.frame_end);
    end

endmodule

`default_nettype wire

[rtl/lpd_out_fifo.sv]
// Two-entry result buffer that decouples the window stage from the output channel.
`default_nettype none

module lpd_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lpd_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output lpd_pkg::t_result      o_result,
    output logic [1:0]            o_count
);

    lpd_pkg::t_result r_entry [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             pop;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_entry[r_rd_ptr];
    assign o_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire
